// ----- rtl/core/pputf8_pkg.sv -----
// ----------------------------------------------------------------------------
// pputf8_pkg
// Types, constants and helper functions shared by the archive path checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pputf8_pkg;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DEL       = 8'h7F;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    localparam logic [20:0] CP_MIN3 = 21'h000800;
    localparam logic [20:0] CP_MIN4 = 21'h010000;
    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;

    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    typedef enum logic [2:0] {
        FAULT_NONE      = 3'd0,
        FAULT_EMPTY     = 3'd1,
        FAULT_BAD_CHAR  = 3'd2,
        FAULT_BAD_COMP  = 3'd3,
        FAULT_BAD_UTF8  = 3'd4
    } fault_code_t;

    // Decoder state of the UTF-8 sequence in flight.
    typedef struct packed {
        logic [1:0]  cont_left;
        logic [1:0]  seq_len;
        logic [20:0] acc;
    } utf8_state_t;

    // Everything that a path carries from one byte to the next.
    typedef struct packed {
        logic        any_byte;
        logic        comp_nonempty;
        logic        comp_ends_bad;
        logic        bad_char;
        logic        bad_comp;
        logic        bad_utf8;
        logic        backslash;
        utf8_state_t utf8;
    } path_state_t;

    typedef struct packed {
        logic [7:0]  norm_byte;
        logic        byte_present;
        logic        verdict_ready;
        logic        path_ok;
        fault_code_t fault_code;
        logic        was_changed;
    } result_t;

    // Ends the current component and flags it if it was empty or ended badly.
    function automatic path_state_t close_component(path_state_t s);
        path_state_t r;
        r = s;
        if (!s.comp_nonempty || s.comp_ends_bad)
        begin
            r.bad_comp = 1'b1;
        end
        r.comp_nonempty = 1'b0;
        r.comp_ends_bad = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pputf8_utf8_step.sv -----
// ----------------------------------------------------------------------------
// pputf8_utf8_step
// Strict UTF-8 decoder step: advances the sequence state by one byte and flags
// overlongs, surrogates, values above U+10FFFF, bad lead bytes, broken sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module pputf8_utf8_step
    import pputf8_pkg::*;
(
    input  wire logic [7:0]  data_byte,
    input  wire utf8_state_t state_in,
    input  wire logic        bad_in,
    output utf8_state_t      state_out,
    output logic             bad_out
);

    logic [20:0] acc_shift;
    logic        cp_bad;
    logic        take_lead;

    assign acc_shift = {state_in.acc[14:0], data_byte[5:0]};

    assign cp_bad = ((state_in.seq_len == SEQ_THREE) && (acc_shift < CP_MIN3))
                 || ((state_in.seq_len == SEQ_FOUR)  && (acc_shift < CP_MIN4))
                 || (acc_shift > CP_MAX)
                 || ((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI));

    always_comb
    begin
        state_out = state_in;
        bad_out   = bad_in;
        take_lead = 1'b1;

        if (state_in.cont_left != 2'd0)
        begin
            if (data_byte[7:6] == 2'b10)
            begin
                take_lead           = 1'b0;
                state_out.acc       = acc_shift;
                state_out.cont_left = state_in.cont_left - 2'd1;
                if (state_in.cont_left == 2'd1)
                begin
                    if (cp_bad)
                    begin
                        bad_out = 1'b1;
                    end
                    state_out.seq_len = SEQ_NONE;
                    state_out.acc     = '0;
                end
            end
            else
            begin
                // A broken sequence ends here; the byte is then taken as a lead.
                bad_out   = 1'b1;
                state_out = '0;
            end
        end

        if (take_lead && data_byte[7])
        begin
            if ((data_byte >= LEAD2_LO) && (data_byte <= LEAD2_HI))
            begin
                state_out.seq_len   = SEQ_TWO;
                state_out.cont_left = 2'd1;
                state_out.acc       = {16'd0, data_byte[4:0]};
            end
            else if ((data_byte >= LEAD3_LO) && (data_byte <= LEAD3_HI))
            begin
                state_out.seq_len   = SEQ_THREE;
                state_out.cont_left = 2'd2;
                state_out.acc       = {17'd0, data_byte[3:0]};
            end
            else if ((data_byte >= LEAD4_LO) && (data_byte <= LEAD4_HI))
            begin
                state_out.seq_len   = SEQ_FOUR;
                state_out.cont_left = 2'd3;
                state_out.acc       = {18'd0, data_byte[2:0]};
            end
            else
            begin
                bad_out = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pputf8_path_step.sv -----
// ----------------------------------------------------------------------------
// pputf8_path_step
// Per-byte path logic: separator normalization, character, component and strict
// UTF-8 checks, and the verdict on the last item of a path.
// ----------------------------------------------------------------------------
`default_nettype none

module pputf8_path_step
    import pputf8_pkg::*;
(
    input  wire logic [7:0]  path_byte,
    input  wire logic        no_byte,
    input  wire logic        last_item,
    input  wire path_state_t state_in,
    output path_state_t      state_out,
    output result_t          result
);

    logic [7:0]  norm;
    utf8_state_t utf8_next;
    logic        utf8_bad_next;

    assign norm = (path_byte == CHAR_BACKSLASH) ? CHAR_SLASH : path_byte;

    pputf8_utf8_step u_utf8 (
        .data_byte (norm),
        .state_in  (state_in.utf8),
        .bad_in    (state_in.bad_utf8),
        .state_out (utf8_next),
        .bad_out   (utf8_bad_next)
    );

    always_comb
    begin
        path_state_t s;
        fault_code_t code;

        s    = state_in;
        code = FAULT_NONE;

        if (!no_byte)
        begin
            s.any_byte = 1'b1;
            if (path_byte == CHAR_BACKSLASH)
            begin
                s.backslash = 1'b1;
            end
            if (norm == CHAR_SLASH)
            begin
                s = close_component(s);
            end
            else
            begin
                if ((path_byte < CHAR_SPACE) || (path_byte == CHAR_DEL)
                    || (path_byte == CHAR_COLON))
                begin
                    s.bad_char = 1'b1;
                end
                s.comp_nonempty = 1'b1;
                s.comp_ends_bad = (path_byte == CHAR_SPACE) || (path_byte == CHAR_DOT);
            end
            s.utf8     = utf8_next;
            s.bad_utf8 = utf8_bad_next;
        end

        result.norm_byte     = no_byte ? 8'd0 : norm;
        result.byte_present  = !no_byte;
        result.verdict_ready = last_item;
        result.path_ok       = 1'b0;
        result.fault_code    = FAULT_NONE;
        result.was_changed   = 1'b0;

        if (last_item)
        begin
            s = close_component(s);
            if (s.utf8.cont_left != 2'd0)
            begin
                s.bad_utf8 = 1'b1;
            end
            if (!s.any_byte)
            begin
                code = FAULT_EMPTY;
            end
            else if (s.bad_char)
            begin
                code = FAULT_BAD_CHAR;
            end
            else if (s.bad_comp)
            begin
                code = FAULT_BAD_COMP;
            end
            else if (s.bad_utf8)
            begin
                code = FAULT_BAD_UTF8;
            end
            result.fault_code  = code;
            result.path_ok     = (code == FAULT_NONE);
            result.was_changed = s.backslash;
            s = '0;
        end

        state_out = s;
    end

endmodule

`default_nettype wire

// ----- rtl/core/package_path_utf8_checker_core.sv -----
// Pipeline: an accepted item goes into the input register, then its result into
// the result register. Throughput: one item per clock unless m_axis_tready stalls;
// the path state is updated as each item moves on to the result register.
// The result register takes a held item when it is empty or being taken downstream.
// Reset: rst_n clears all valid flags and the per-path state, so the first
// item after reset starts a new path.
// ----------------------------------------------------------------------------
// package_path_utf8_checker_core
// Archive path checker: normalizes separators, checks characters, components
// and strict UTF-8, and gives a verdict on the last item of each path.
// ----------------------------------------------------------------------------
`default_nettype none

module package_path_utf8_checker_core
    import pputf8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] path_byte
    input  wire logic        s_axis_tuser,   // no_byte
    input  wire logic        s_axis_tlast,   // last_item

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] norm_byte, [8] path_ok,
                                             // [11:9] fault_code, [12] was_changed
    output logic             m_axis_tuser,   // byte_present
    output logic             m_axis_tlast    // verdict_ready
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_none_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;

    path_state_t state_reg;
    path_state_t state_next;
    result_t     step_result;

    logic        advance;
    logic        accept;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    pputf8_path_step u_step (
        .path_byte (in_byte_reg),
        .no_byte   (in_none_reg),
        .last_item (in_last_reg),
        .state_in  (state_reg),
        .state_out (state_next),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_none_reg <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_reg.was_changed, out_reg.fault_code,
                            out_reg.path_ok, out_reg.norm_byte};
    assign m_axis_tuser  = out_reg.byte_present;
    assign m_axis_tlast  = out_reg.verdict_ready;

    // The path state is fully cleared once the last item of a path goes through.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (state_reg == '0))
        else $error("path state not cleared after verdict");

    // Verdict fields stay zero on results that are not the verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[12:8] == 5'd0))
        else $error("verdict fields set outside verdict");

    // path_ok agrees with the fault code on every verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast)
            |-> (m_axis_tdata[8] == (m_axis_tdata[11:9] == FAULT_NONE)))
        else $error("path_ok disagrees with fault code");

    // No byte may leave the block in a slot that carries none.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("norm_byte set without a byte");

endmodule

`default_nettype wire
